// ===== sv/dfmu_pkg.sv =====
// Package for the domain feedback map update block.
// Holds field widths, opcode and register index codes and the update function.
// No dependencies.
package dfmu_pkg;

  localparam int OPCODE_W    = 3;
  localparam int DOMAIN_W    = 2;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = 12;
  localparam int SIZE_W      = 11;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int SIZE_REGS   = 4;
  localparam int START_W     = SIZE_W + 2;
  localparam int SLOT_SUM_W  = START_W + 1;

  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_CYCLES    = KEY_W / MOD_STEP_BITS;
  localparam int MOD_CNT_W     = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OPCODE_W-1:0] OP_MAX  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_OR   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd4;

  function automatic logic [DATA_W-1:0] apply_op(
    input logic [OPCODE_W-1:0] op,
    input logic [DATA_W-1:0]   cur,
    input logic [DATA_W-1:0]   val
  );
    logic [DATA_W-1:0] res;
    case (op)
      OP_MAX:  res = (cur > val) ? cur : val;
      OP_SET:  res = val;
      OP_OR:   res = cur | val;
      OP_ADD:  res = cur + val;
      OP_READ: res = cur;
      default: res = cur;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/dfmu_mod.sv =====
// Iterative key modulo region size unit, several remainder digits per cycle.
// Depends on dfmu_pkg.
module dfmu_mod
  import dfmu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [SIZE_W-1:0] rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MOD_CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0]     key_q;
  logic [SIZE_W-1:0]    div_q;
  logic [SIZE_W-1:0]    rem_q;
  logic [SIZE_W-1:0]    rem_d;

  always_comb begin
    logic [SIZE_W:0] t;
    logic [SIZE_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < MOD_STEP_BITS; i++) begin
      t = {r, key_q[KEY_W-1-i]};
      if (t >= {1'b0, div_q}) begin
        r = SIZE_W'(t - {1'b0, div_q});
      end else begin
        r = t[SIZE_W-1:0];
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      key_q <= key_q << MOD_STEP_BITS;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/dfmu_store.sv =====
// Feedback store: single-port synchronous memory with a clearing sweep after reset.
// Depends on dfmu_pkg.
module dfmu_store
  import dfmu_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              ready_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              clr_busy_q;
  logic [AW-1:0]     clr_addr_q;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign we = clr_busy_q || wr_en_i;
  assign wa = clr_busy_q ? clr_addr_q : addr_i;
  assign wd = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

// ===== sv/domain_feedback_map_update.sv =====
// Top level of the domain feedback map update block.
// Depends on dfmu_pkg, dfmu_mod and dfmu_store.
//
//  port group  direction  handshake             payload
//  in          to block   in_valid_i/in_stall_o opcode, domain, key, update_value
//  out         from block out_valid_o/out_stall_i slot, new_contents, bad_domain
//  cfg         to block   cfg_we_i              cfg_index_i, cfg_data_i
//
// An item in a valid domain goes from accept through the modulo unit (8 key bits a
// cycle), one memory read, and one update and write back into the output register.
// A bad domain item skips the modulo unit and the store and goes to write back.
// After reset the store is swept to zero, all DOMAINS*REGION_ENTRIES entries (4096 by
// default); no item is taken meanwhile. A finished result waits in the output
// register under out_stall_i while the next item is accepted and processed.
module domain_feedback_map_update
  import dfmu_pkg::*;
#(
  parameter int DOMAINS        = 4,
  parameter int REGION_ENTRIES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OPCODE_W-1:0]   opcode_i,
  input  logic [DOMAIN_W-1:0]   domain_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [DATA_W-1:0]     update_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [DATA_W-1:0]     new_contents_o,
  output logic                  bad_domain_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH = DOMAINS * REGION_ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_e;

  state_e                st_q;
  logic [COUNT_W-1:0]    count_q;
  logic [SIZE_W-1:0]     size_q [SIZE_REGS];
  logic [SIZE_W-1:0]     eff_size [SIZE_REGS];
  logic [START_W-1:0]    start_in;
  logic                  bad_in;
  logic [OPCODE_W-1:0]   op_q;
  logic [DATA_W-1:0]     val_q;
  logic                  bad_q;
  logic [START_W-1:0]    start_q;
  logic [SLOT_SUM_W-1:0] slot_q;
  logic [SLOT_SUM_W-1:0] slot_sum;
  logic                  out_valid_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [DATA_W-1:0]     out_data_q;
  logic                  out_bad_q;
  logic                  accept;
  logic                  out_free;
  logic                  mod_start;
  logic                  mod_done;
  logic [SIZE_W-1:0]     mod_rem;
  logic                  store_rd;
  logic                  store_wr;
  logic [AW-1:0]         store_addr;
  logic [DATA_W-1:0]     store_rdata;
  logic                  store_ready;
  logic [DATA_W-1:0]     new_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < SIZE_REGS; i++) begin
        size_q[i] <= SIZE_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COUNT: count_q   <= cfg_data_i[COUNT_W-1:0];
        REG_SIZE0: size_q[0] <= cfg_data_i;
        REG_SIZE1: size_q[1] <= cfg_data_i;
        REG_SIZE2: size_q[2] <= cfg_data_i;
        REG_SIZE3: size_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < SIZE_REGS; i++) begin
      if (size_q[i] == '0) begin
        eff_size[i] = SIZE_W'(1);
      end else if (32'(size_q[i]) > 32'(REGION_ENTRIES)) begin
        eff_size[i] = SIZE_W'(REGION_ENTRIES);
      end else begin
        eff_size[i] = size_q[i];
      end
    end
  end

  always_comb begin
    start_in = '0;
    for (int i = 0; i < SIZE_REGS; i++) begin
      if (32'(i) < 32'(domain_i)) begin
        start_in = start_in + START_W'(eff_size[i]);
      end
    end
  end

  assign bad_in = 32'(domain_i) >= ((32'(count_q) > 32'(DOMAINS)) ? 32'(DOMAINS)
                                                                   : 32'(count_q));

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((st_q == ST_IDLE) || ((st_q == ST_WB) && out_free));
  assign accept     = in_valid_i && !in_stall_o;
  assign mod_start  = accept && !bad_in;

  dfmu_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .key_i     (key_i),
    .divisor_i (eff_size[domain_i]),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign slot_sum   = SLOT_SUM_W'(start_q) + SLOT_SUM_W'(mod_rem);
  assign store_rd   = (st_q == ST_DIV) && mod_done;
  assign store_wr   = (st_q == ST_WB) && out_free && !bad_q;
  assign store_addr = store_rd ? AW'(slot_sum) : AW'(slot_q);
  assign new_val    = apply_op(op_q, store_rdata, val_q);

  dfmu_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (store_rd),
    .wr_en_i (store_wr),
    .addr_i  (store_addr),
    .wdata_i (new_val),
    .rdata_o (store_rdata),
    .ready_o (store_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      out_valid_q <= 1'b0;
      out_slot_q  <= '0;
      out_data_q  <= '0;
      out_bad_q   <= 1'b0;
      op_q        <= '0;
      val_q       <= '0;
      bad_q       <= 1'b0;
      start_q     <= '0;
      slot_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_CLEAR: begin
          if (store_ready) begin
            st_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (mod_done) begin
            slot_q <= slot_sum;
            st_q   <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_bad_q   <= bad_q;
            out_slot_q  <= bad_q ? '0 : SLOT_W'(slot_q);
            out_data_q  <= bad_q ? '0 : new_val;
            st_q        <= ST_IDLE;
          end
        end
        default: ;
      endcase
      if (accept) begin
        op_q    <= opcode_i;
        val_q   <= update_value_i;
        bad_q   <= bad_in;
        start_q <= start_in;
        st_q    <= bad_in ? ST_WB : ST_DIV;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_o         = out_slot_q;
  assign new_contents_o = out_data_q;
  assign bad_domain_o   = out_bad_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> store_ready)
    else $error("item accepted during store clear");

  a_bad_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_domain_o) |-> (slot_o == '0 && new_contents_o == '0))
    else $error("bad domain result carries data");

  a_mod_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (st_q == ST_DIV))
    else $error("modulo result outside divide state");

  a_rd_wr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_rd && store_wr))
    else $error("store read and write in one cycle");

  a_wb_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_rd |=> (st_q == ST_WB && !bad_q))
    else $error("store read not followed by write back");

endmodule

// ===== test/tb_domain_feedback_map_update.sv =====
// Testbench for domain_feedback_map_update: a directed table, then random items
// under several register settings, checked against a local model of the store.
// Depends on dfmu_pkg and the domain_feedback_map_update RTL.
module tb_domain_feedback_map_update
  import dfmu_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOMAINS         = 4;
  localparam int REGION_ENTRIES  = 1024;
  localparam int STORE_DEPTH     = DOMAINS * REGION_ENTRIES;
  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_LIMIT     = 20000;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 16;
  localparam int BLOCKS          = 6;
  localparam int ITEMS_PER_BLOCK = 92;
  localparam int MAX_REPORTS     = 10;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] contents;
    logic              bad;
  } feedback_res_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [OPCODE_W-1:0]   op;
    logic [DOMAIN_W-1:0]   dom;
    logic [KEY_W-1:0]      key_v;
    logic [DATA_W-1:0]     val;
    logic                  typed;
    feedback_res_t         res;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } dir_row_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [OPCODE_W-1:0]   opcode_i       = '0;
  logic [DOMAIN_W-1:0]   domain_i       = '0;
  logic [KEY_W-1:0]      key_i          = '0;
  logic [DATA_W-1:0]     update_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [SLOT_W-1:0]     slot_o;
  logic [DATA_W-1:0]     new_contents_o;
  logic                  bad_domain_o;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  logic [DATA_W-1:0]  store_model [STORE_DEPTH];
  logic [COUNT_W-1:0] count_model;
  logic [SIZE_W-1:0]  size_model [SIZE_REGS];

  feedback_res_t pending_results [$];
  dir_row_t      dir_rows [$];

  int errors       = 0;
  int quiet_cycles = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  domain_feedback_map_update #(
    .DOMAINS        (DOMAINS),
    .REGION_ENTRIES (REGION_ENTRIES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .domain_i       (domain_i),
    .key_i          (key_i),
    .update_value_i (update_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_o         (slot_o),
    .new_contents_o (new_contents_o),
    .bad_domain_o   (bad_domain_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int unsigned region_size(int d);
    int unsigned s;
    s = size_model[d];
    if (s == 0) s = 1;
    if (s > REGION_ENTRIES) s = REGION_ENTRIES;
    return s;
  endfunction

  function automatic int unsigned active_count();
    return (count_model > DOMAINS) ? DOMAINS : count_model;
  endfunction

  function automatic feedback_res_t apply_feedback(
    input logic [OPCODE_W-1:0] op,
    input logic [DOMAIN_W-1:0] dom,
    input logic [KEY_W-1:0]    key_v,
    input logic [DATA_W-1:0]   val
  );
    feedback_res_t     r;
    logic [31:0]       start;
    logic [31:0]       slot;
    logic [DATA_W-1:0] cur;
    r = '0;
    if (int'(dom) >= active_count()) begin
      r.bad = 1'b1;
      return r;
    end
    start = 0;
    for (int d = 0; d < int'(dom); d++) start += region_size(d);
    slot = start + key_v % region_size(int'(dom));
    cur = store_model[slot];
    case (op)
      OP_MAX: begin
        if (val > cur) cur = val;
      end
      OP_SET:  cur = val;
      OP_OR:   cur = cur | val;
      OP_ADD:  cur = cur + val;
      default: ;
    endcase
    store_model[slot] = cur;
    r.slot = slot[SLOT_W-1:0];
    r.contents = cur;
    return r;
  endfunction

  function automatic feedback_res_t res_of(int slot, logic [DATA_W-1:0] contents, logic bad);
    feedback_res_t r;
    r.slot = SLOT_W'(slot);
    r.contents = contents;
    r.bad = bad;
    return r;
  endfunction

  function automatic dir_row_t item_row(
    logic [OPCODE_W-1:0] op, logic [DOMAIN_W-1:0] dom,
    logic [KEY_W-1:0] key_v, logic [DATA_W-1:0] val
  );
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.dom = dom;
    r.key_v = key_v;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t checked_row(
    logic [OPCODE_W-1:0] op, logic [DOMAIN_W-1:0] dom,
    logic [KEY_W-1:0] key_v, logic [DATA_W-1:0] val, feedback_res_t res
  );
    dir_row_t r;
    r = item_row(op, dom, key_v, val);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic dir_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return SIZE_W'($urandom_range(0, 4));
      1:       return SIZE_W'($urandom_range(0, 2047));
      default: return SIZE_W'($urandom_range(1, 32));
    endcase
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == REG_COUNT) count_model = val[COUNT_W-1:0];
    else if (idx >= REG_SIZE0 && idx <= REG_SIZE3) size_model[idx - REG_SIZE0] = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(
    input logic [OPCODE_W-1:0] op,
    input logic [DOMAIN_W-1:0] dom,
    input logic [KEY_W-1:0]    key_v,
    input logic [DATA_W-1:0]   val,
    input logic                typed,
    input feedback_res_t       typed_res
  );
    feedback_res_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    domain_i       <= dom;
    key_i          <= key_v;
    update_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_feedback(op, dom, key_v, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  always @(posedge clk_i) begin : rx_side
    feedback_res_t got;
    feedback_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.slot = slot_o;
      got.contents = new_contents_o;
      got.bad = bad_domain_o;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: slot %0d contents %h bad %0b",
                               got.slot, got.contents, got.bad));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf(
            "mismatch: slot exp %0d got %0d, contents exp %h got %h, bad exp %0b got %0b",
            want.slot, got.slot, want.contents, got.contents, want.bad, got.bad));
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main
    logic [OPCODE_W-1:0] op;
    logic [DOMAIN_W-1:0] dom;
    logic [KEY_W-1:0]    key_v;
    logic [DATA_W-1:0]   val;
    int unsigned         act;
    feedback_res_t       bad_res;

    for (int s = 0; s < STORE_DEPTH; s++) store_model[s] = '0;
    count_model = '0;
    for (int d = 0; d < SIZE_REGS; d++) size_model[d] = SIZE_RESET;
    bad_res = res_of(0, '0, 1'b1);

    dir_rows.push_back(checked_row(OP_SET, 2'd0, 32'h0, 32'hFFFF_FFFF, bad_res));
    dir_rows.push_back(checked_row(OP_ADD, 2'd3, 32'hFFFF_FFFF, 32'h1, bad_res));
    dir_rows.push_back(write_row(REG_COUNT, 11'd4));
    dir_rows.push_back(checked_row(OP_SET, 2'd0, 32'h0, 32'hFFFF_FFFF,
                                   res_of(0, 32'hFFFF_FFFF, 1'b0)));
    dir_rows.push_back(checked_row(OP_ADD, 2'd0, 32'h0, 32'h1, res_of(0, 32'h0, 1'b0)));
    dir_rows.push_back(checked_row(OP_MAX, 2'd0, 32'd1024, 32'h5, res_of(0, 32'h5, 1'b0)));
    dir_rows.push_back(checked_row(OP_MAX, 2'd0, 32'h0, 32'h3, res_of(0, 32'h5, 1'b0)));
    dir_rows.push_back(checked_row(OP_OR, 2'd0, 32'h0, 32'hA0, res_of(0, 32'hA5, 1'b0)));
    dir_rows.push_back(checked_row(OP_READ, 2'd0, 32'h0, 32'hFFFF_FFFF,
                                   res_of(0, 32'hA5, 1'b0)));
    dir_rows.push_back(checked_row(OP_SPARE_LO, 2'd0, 32'h0, 32'h1, res_of(0, 32'hA5, 1'b0)));
    dir_rows.push_back(checked_row(OP_SPARE_HI, 2'd0, 32'hFFFF_FFFF, 32'h1,
                                   res_of(1023, 32'h0, 1'b0)));
    dir_rows.push_back(checked_row(OP_SET, 2'd3, 32'hFFFF_FFFF, 32'h1234_5678,
                                   res_of(4095, 32'h1234_5678, 1'b0)));
    dir_rows.push_back(checked_row(OP_READ, 2'd3, 32'd1023, 32'h0,
                                   res_of(4095, 32'h1234_5678, 1'b0)));
    dir_rows.push_back(checked_row(OP_ADD, 2'd1, 32'd5, 32'hFFFF_FFFF,
                                   res_of(1029, 32'hFFFF_FFFF, 1'b0)));
    dir_rows.push_back(checked_row(OP_MAX, 2'd2, 32'h0, 32'h8000_0000,
                                   res_of(2048, 32'h8000_0000, 1'b0)));
    dir_rows.push_back(checked_row(OP_MAX, 2'd2, 32'h0, 32'h7FFF_FFFF,
                                   res_of(2048, 32'h8000_0000, 1'b0)));
    dir_rows.push_back(write_row(REG_SIZE0, 11'd0));
    dir_rows.push_back(write_row(REG_SIZE1, 11'd2047));
    dir_rows.push_back(write_row(REG_SIZE2, 11'd1));
    dir_rows.push_back(write_row(REG_COUNT, 11'd7));
    dir_rows.push_back(checked_row(OP_SET, 2'd0, 32'hFFFF_FFFF, 32'h7, res_of(0, 32'h7, 1'b0)));
    dir_rows.push_back(item_row(OP_READ, 2'd1, 32'hFFFF_FFFF, 32'h0));
    dir_rows.push_back(item_row(OP_ADD, 2'd2, 32'd12345, 32'h1));
    dir_rows.push_back(item_row(OP_OR, 2'd3, 32'd77, 32'h0F0F_0F0F));
    dir_rows.push_back(item_row(OP_MAX, 2'd3, 32'hFFFF_FFFF, 32'h0));
    dir_rows.push_back(write_row(REG_COUNT, 11'd2));
    dir_rows.push_back(checked_row(OP_SET, 2'd2, 32'h0, 32'h1, bad_res));
    dir_rows.push_back(item_row(OP_READ, 2'd1, 32'h0, 32'h0));
    dir_rows.push_back(item_row(OP_ADD, 2'd0, 32'h0, 32'hFFFF_FFF9));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 8;
    rcv_idle_pct <= 51;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_item(dir_rows[r].op, dir_rows[r].dom, dir_rows[r].key_v, dir_rows[r].val,
                  dir_rows[r].typed, dir_rows[r].res);
      end
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      wait_idle();
      if (blk == 0) begin
        write_reg(REG_COUNT, 11'd7);
        write_reg(REG_SIZE0, 11'd0);
        write_reg(REG_SIZE1, 11'd2047);
        write_reg(REG_SIZE2, 11'd1024);
        write_reg(REG_SIZE3, 11'd1);
      end else if (blk == BLOCKS - 1) begin
        write_reg(REG_COUNT, 11'd4);
        for (int d = 0; d < SIZE_REGS; d++)
          write_reg(CFG_IDX_W'(REG_SIZE0 + d), 11'd1024);
      end else begin
        write_reg(REG_COUNT, CFG_DATA_W'($urandom_range(1, 7)));
        for (int d = 0; d < SIZE_REGS; d++)
          write_reg(CFG_IDX_W'(REG_SIZE0 + d), pick_size());
      end
      if (blk < 2) begin
        snd_idle_pct = 8;
        rcv_idle_pct <= 51;
      end else if (blk < 4) begin
        snd_idle_pct = 51;
        rcv_idle_pct <= 8;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
      end
      if (blk == 1 || blk == 4) hold_seq <= hold_seq + 1;
      act = active_count();
      for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
        if (blk == 3 && n == ITEMS_PER_BLOCK / 2) wait_idle();
        if ($urandom_range(0, 99) < 70) op = OPCODE_W'($urandom_range(0, 4));
        else op = OPCODE_W'($urandom_range(0, 7));
        if (act > 0 && $urandom_range(0, 99) < 85) dom = DOMAIN_W'($urandom_range(0, act - 1));
        else dom = DOMAIN_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) key_v = $urandom_range(0, 64);
        else key_v = $urandom;
        case ($urandom_range(0, 3))
          0:       val = $urandom | 32'hF000_0000;
          1:       val = $urandom_range(0, 255);
          default: val = $urandom;
        endcase
        send_item(op, dom, key_v, val, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dfmu_pkg.sv
sv/dfmu_mod.sv
sv/dfmu_store.sv
sv/domain_feedback_map_update.sv
test/tb_domain_feedback_map_update.sv
